// ----- design/wua_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wua_pkg: shared types and constants of the wide unsigned alu
// widths, operation codes and the control bundle for the bit-serial lanes
// ----------------------------------------------------------------------------
package wua_pkg;

   localparam int WordW  = 64;
   localparam int Words  = 4;
   localparam int DataW  = WordW * Words;
   localparam int CntW   = 8;
   localparam int AmtW   = 8;
   localparam int OpW    = 3;
   localparam int ReqW   = 2 * DataW + AmtW;

   localparam logic [OpW-1:0] OP_ADD = 3'd0;
   localparam logic [OpW-1:0] OP_SUB = 3'd1;
   localparam logic [OpW-1:0] OP_NEG = 3'd2;
   localparam logic [OpW-1:0] OP_MUL = 3'd3;
   localparam logic [OpW-1:0] OP_SHL = 3'd4;

   // control bundle from the sequencer to the serial lanes
   typedef struct packed {
      logic           clear;
      logic           step;
      logic [OpW-1:0] op;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ----- design/wua_serial_adder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wua_serial_adder: bit-serial add, subtract and negate lane
// one full adder and a carry flop, lsb first
// ----------------------------------------------------------------------------
module wua_serial_adder
   import wua_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lane_ctrl_type ctrl,
   input  wire logic          a_bit,
   input  wire logic          b_bit,
   output logic               sum_bit
);

   logic carry_ff;
   logic carry_in;
   logic x_bit;
   logic y_bit;
   logic cout;

   always_comb begin
      x_bit = a_bit;
      y_bit = b_bit;
      case (ctrl.op)
         OP_SUB: begin
            y_bit = ~b_bit;
         end
         OP_NEG: begin
            x_bit = ~a_bit;
            y_bit = 1'b0;
         end
         default: begin
            x_bit = a_bit;
            y_bit = b_bit;
         end
      endcase
      sum_bit = x_bit ^ y_bit ^ carry_ff;
      cout    = (x_bit & y_bit) | (x_bit & carry_ff) | (y_bit & carry_ff);
   end

   // two's complement forms start with a carry of one
   always_comb begin
      carry_in = carry_ff;
      if (ctrl.clear) begin
         carry_in = ctrl.op inside {OP_SUB, OP_NEG};
      end else if (ctrl.step) begin
         carry_in = cout;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
      end else begin
         carry_ff <= carry_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/wua_csa_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wua_csa_mul: serial-parallel multiplier with a carry-save accumulator
// one multiplier bit per step, one product bit out per step, lsb first
// ----------------------------------------------------------------------------
module wua_csa_mul
   import wua_pkg::*;
(
   input  wire logic             clock,
   input  wire lane_ctrl_type    ctrl,
   input  wire logic             mult_bit,
   input  wire logic [DataW-1:0] mcand,
   output logic                  prod_bit
);

   logic [DataW-1:0] sum_ff;
   logic [DataW-1:0] carry_ff;
   logic [DataW-1:0] sum_in;
   logic [DataW-1:0] carry_in;
   logic [DataW-1:0] pp;
   logic [DataW-1:0] cell_sum;
   logic [DataW-1:0] cell_carry;

   // each cell is an independent full adder, no carry ripple
   always_comb begin
      pp         = mult_bit ? mcand : '0;
      cell_sum   = sum_ff ^ carry_ff ^ pp;
      cell_carry = (sum_ff & carry_ff) | (sum_ff & pp) | (carry_ff & pp);
      prod_bit   = cell_sum[0];
      sum_in     = sum_ff;
      carry_in   = carry_ff;
      if (ctrl.clear) begin
         sum_in   = '0;
         carry_in = '0;
      end else if (ctrl.step) begin
         // drop the emitted bit, carries move up one weight
         sum_in   = {1'b0, cell_sum[DataW-1:1]};
         carry_in = cell_carry;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      carry_ff <= carry_in;
   end

endmodule

`default_nettype wire

// ----- design/wide_unsigned_alu_256_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wide_unsigned_alu_256_top: bit-serial 256-bit unsigned alu
// add, subtract, negate, low-half multiply and left shift, one result bit
// per clock out of shift registers
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake           payload
//   req      in   req_tvalid/tready   tuser: operation
//                                     tdata: a_word0..3, b_word0..3, shift_amount
//   rsp      out  rsp_tvalid/tready   tdata: r_word0..3
//
// every operation takes 256 steps, one result bit per step, set by the
// 256-bit result width that the step counter runs through
// once the output register is free, the hold state moves the finished word
// into it and rsp_tvalid rises
// reset clears the sequencer and the output valid; operands are not reset
// one item in the core at a time; a new beat is taken while the previous
// result still waits on rsp_tready
//
module wide_unsigned_alu_256_top
   import wua_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request side
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [ReqW-1:0]   req_tdata,   // a_word0..3, b_word0..3, shift_amount
   input  wire logic [OpW-1:0]    req_tuser,   // operation
   // response side
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DataW-1:0]       rsp_tdata    // r_word0..3
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [CntW-1:0]  cnt_ff;
   logic [CntW-1:0]  cnt_in;
   logic [OpW-1:0]   op_ff;
   logic [OpW-1:0]   op_in;
   logic [AmtW-1:0]  amt_ff;
   logic [AmtW-1:0]  amt_in;
   logic [DataW-1:0] a_ff;
   logic [DataW-1:0] a_in;
   logic [DataW-1:0] b_ff;
   logic [DataW-1:0] b_in;
   logic [DataW-1:0] r_ff;
   logic [DataW-1:0] r_in;
   logic [DataW-1:0] out_ff;
   logic [DataW-1:0] out_in;
   logic             out_valid_ff;
   logic             out_valid_in;

   logic             req_beat;
   logic             step;
   logic             last_step;
   logic             out_free;
   logic             shift_pad;
   logic             res_bit;
   logic             add_bit;
   logic             mul_bit;
   lane_ctrl_type    ctrl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign step       = (state_ff == ST_RUN);
   assign last_step  = (cnt_ff == CntW'(DataW - 1));
   assign out_free   = !out_valid_ff || rsp_tready;
   // shift emits zeros until the count reaches the distance
   assign shift_pad  = (cnt_ff < amt_ff);

   // lanes are cleared on the accept beat with the incoming operation
   always_comb begin
      ctrl.clear = req_beat;
      ctrl.step  = step;
      ctrl.op    = req_beat ? req_tuser : op_ff;
   end

   wua_serial_adder u_adder (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .a_bit   (a_ff[0]),
      .b_bit   (b_ff[0]),
      .sum_bit (add_bit)
   );

   wua_csa_mul u_mul (
      .clock    (clock),
      .ctrl     (ctrl),
      .mult_bit (a_ff[0]),
      .mcand    (b_ff),
      .prod_bit (mul_bit)
   );

   // result bit select
   always_comb begin
      case (op_ff)
         OP_ADD, OP_SUB, OP_NEG: res_bit = add_bit;
         OP_MUL:                 res_bit = mul_bit;
         OP_SHL:                 res_bit = shift_pad ? 1'b0 : a_ff[0];
         default:                res_bit = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // operand and result shift registers
   always_comb begin
      op_in  = op_ff;
      amt_in = amt_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      r_in   = r_ff;
      if (req_beat) begin
         op_in  = req_tuser;
         a_in   = req_tdata[DataW-1:0];
         b_in   = req_tdata[2*DataW-1:DataW];
         amt_in = req_tdata[ReqW-1:2*DataW];
      end else if (step) begin
         r_in = {res_bit, r_ff[DataW-1:1]};
         // a holds still during the zero fill of a shift
         if (!((op_ff == OP_SHL) && shift_pad)) begin
            a_in = {1'b0, a_ff[DataW-1:1]};
         end
         // multiplicand stays parallel for the multiplier array
         if (op_ff != OP_MUL) begin
            b_in = {1'b0, b_ff[DataW-1:1]};
         end
      end
   end

   // output register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if ((state_ff == ST_HOLD) && out_free) begin
         out_in       = r_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      amt_ff <= amt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

`default_nettype wire

// ----- design/wua_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wua_checker: port-level checks of the wide unsigned alu
// watches the request and response channels over time
// ----------------------------------------------------------------------------
module wua_checker
   import wua_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [DataW-1:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

   // one item in the core: no second beat right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while core busy");

   // nothing is shown out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a new result only appears while the core is closed to requests
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a busy core");

   // the core is still closed partway through the serial pass
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##200 !req_tready)
      else $error("core reopened before the serial pass ended");

endmodule

bind wide_unsigned_alu_256_top wua_checker u_wua_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- dv/wide_unsigned_alu_256_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_unsigned_alu_256_checker: result predictor and scoreboard
// predicts each 256-bit result from the accepted request beats and compares
// every response beat word by word against the oldest prediction
// ----------------------------------------------------------------------------
module wide_unsigned_alu_256_checker
   import wua_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [ReqW-1:0]   req_tdata,   // a_word0..3, b_word0..3, shift_amount
   input  wire logic [OpW-1:0]    req_tuser,   // operation
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [DataW-1:0]  rsp_tdata,   // r_word0..3
   output int                     fail_count,
   output int                     pending_count
);

   logic [DataW-1:0] expected_results[$];
   logic [DataW-1:0] want;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      fail_count++;
   endtask

   // everything wraps at 2^256: the 256-bit result width drops the carries
   function automatic logic [DataW-1:0] alu_result(input logic [OpW-1:0] op,
                                                   input logic [DataW-1:0] a,
                                                   input logic [DataW-1:0] b,
                                                   input logic [AmtW-1:0] amt);
      logic [DataW-1:0] r;
      case (op)
         OP_ADD:  r = a + b;
         OP_SUB:  r = a - b;
         OP_NEG:  r = '0 - a;
         OP_MUL:  r = a * b;
         OP_SHL:  r = a << amt;
         default: r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         // retire before predicting so a same-edge result never meets its own beat
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing expected", rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               for (int i = 0; i < Words; i++) begin
                  if (rsp_tdata[i*WordW +: WordW] !== want[i*WordW +: WordW])
                     report_mismatch($sformatf("r_word%0d got %h expected %h", i,
                                     rsp_tdata[i*WordW +: WordW], want[i*WordW +: WordW]));
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(alu_result(req_tuser, req_tdata[DataW-1:0],
                                                  req_tdata[2*DataW-1:DataW],
                                                  req_tdata[ReqW-1 -: AmtW]));
         pending_count = expected_results.size();
      end
   end

endmodule

// ----- dv/wide_unsigned_alu_256_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_unsigned_alu_256_top_test: testbench of the bit-serial 256-bit alu
// directed corner operands then weighted random beats, bursty sender and a
// stalling receiver; the checker predicts and scores every result
// ----------------------------------------------------------------------------
module wide_unsigned_alu_256_top_test;
   import wua_pkg::*;

   // codes the block leaves unused, they must return zero
   localparam logic [OpW-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OpW-1:0] OP_SPARE_LAST  = 3'd7;

   localparam int RandomItems = 400;
   // leave room at the end past the time that one item holds the core
   localparam int DrainCycles = 320;

   localparam logic [DataW-1:0] ALL_ONES = '1;
   localparam logic [DataW-1:0] ONE      = 256'd1;
   localparam logic [DataW-1:0] TOP_BIT  = ONE << 255;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [ReqW-1:0]   req_tdata = '0;   // a_word0..3, b_word0..3, shift_amount
   logic [OpW-1:0]    req_tuser = '0;   // operation
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DataW-1:0]  rsp_tdata;        // r_word0..3
   int                fail_count;
   int                pending_count;

   // sender burst bookkeeping
   int                burst_left = 0;

   // receiver stall pattern: segments of always-ready, coin-flip or mostly-stalled
   int                segment_left = 0;
   int                segment_kind = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   wide_unsigned_alu_256_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wide_unsigned_alu_256_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // receiver: a new segment of random length and kind each time one runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(1, 600);
            segment_kind = $urandom_range(0, 2);
         end else begin
            segment_left--;
         end
         case (segment_kind)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // one beat onto the request channel; valid stays high across a burst
   task automatic send_beat(input logic [OpW-1:0] op, input logic [DataW-1:0] a,
                            input logic [DataW-1:0] b, input logic [AmtW-1:0] amt);
      int gap;
      if (burst_left == 0) begin
         // mostly short gaps, now and then long enough to let the core go idle
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(100, 400);
            default: gap = $urandom_range(1, 20);
         endcase
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {amt, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // word patterns that hit carries, borrows and every bit position
   function automatic logic [WordW-1:0] pick_word();
      logic [WordW-1:0] w;
      case ($urandom_range(0, 9))
         0:       w = '0;
         1:       w = '1;
         2:       w = 64'd1 << $urandom_range(0, 63);
         3:       w = ~(64'd1 << $urandom_range(0, 63));
         4:       w = WordW'($urandom_range(0, 255));
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   function automatic logic [DataW-1:0] pick_operand();
      logic [DataW-1:0] v;
      for (int i = 0; i < Words; i++) v[i*WordW +: WordW] = pick_word();
      // narrow operands now and then so products stay below the wrap
      if ($urandom_range(0, 5) == 0) v = v >> ($urandom_range(1, 4) * WordW / 2);
      return v;
   endfunction

   function automatic logic [OpW-1:0] pick_op();
      int r;
      logic [OpW-1:0] op;
      r = $urandom_range(0, 99);
      if (r < 18)       op = OP_ADD;
      else if (r < 36)  op = OP_SUB;
      else if (r < 50)  op = OP_NEG;
      else if (r < 72)  op = OP_MUL;
      else if (r < 94)  op = OP_SHL;
      else              op = OpW'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      return op;
   endfunction

   // stimulus and verdict
   initial begin
      logic [AmtW-1:0] amt;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // add: zeros, full wrap, carry rippling through every word
      send_beat(OP_ADD, '0, '0, 8'hff);
      send_beat(OP_ADD, ALL_ONES, ALL_ONES, 8'h00);
      send_beat(OP_ADD, ALL_ONES, ONE, 8'h5a);
      send_beat(OP_ADD, {4{64'hffff_ffff_ffff_ffff}} >> 1, ONE, 8'd0);
      // subtract: borrow out of the top, equal operands, zero minus max
      send_beat(OP_SUB, '0, ONE, 8'd0);
      send_beat(OP_SUB, ALL_ONES, ALL_ONES, 8'hff);
      send_beat(OP_SUB, '0, ALL_ONES, 8'd3);
      send_beat(OP_SUB, ALL_ONES, '0, 8'd0);
      // negate ignores b and the amount
      send_beat(OP_NEG, '0, ALL_ONES, 8'hff);
      send_beat(OP_NEG, ONE, ALL_ONES, 8'd1);
      send_beat(OP_NEG, ALL_ONES, '0, 8'd0);
      send_beat(OP_NEG, TOP_BIT, ONE, 8'd7);
      // multiply: zero, max squared wraps to one, top bit shifted out
      send_beat(OP_MUL, ALL_ONES, '0, 8'd0);
      send_beat(OP_MUL, ALL_ONES, ALL_ONES, 8'hff);
      send_beat(OP_MUL, TOP_BIT, 256'd2, 8'd0);
      send_beat(OP_MUL, {64'd0, 64'd0, 64'd0, 64'hffff_ffff_ffff_ffff},
                        {64'd0, 64'd0, 64'd0, 64'hffff_ffff_ffff_ffff}, 8'd0);
      // shift: zero distance, word boundaries, maximum distance
      send_beat(OP_SHL, ALL_ONES, ALL_ONES, 8'd0);
      send_beat(OP_SHL, ALL_ONES, '0, 8'd63);
      send_beat(OP_SHL, ALL_ONES, '0, 8'd64);
      send_beat(OP_SHL, ALL_ONES, ALL_ONES, 8'd128);
      send_beat(OP_SHL, ONE, '0, 8'd255);
      send_beat(OP_SHL, ALL_ONES, '0, 8'd255);
      // unused codes return zero whatever the operands
      send_beat(OP_SPARE_FIRST, ALL_ONES, ALL_ONES, 8'hff);
      send_beat(OP_SPARE_FIRST + 3'd1, ALL_ONES, ONE, 8'd1);
      send_beat(OP_SPARE_LAST, ONE, ALL_ONES, 8'd128);

      for (int n = 0; n < RandomItems; n++) begin
         // shift distances lean on the word edges
         case ($urandom_range(0, 3))
            0:       amt = AmtW'(($urandom_range(0, 3) * WordW) + $urandom_range(0, 1));
            1:       amt = AmtW'(($urandom_range(1, 4) * WordW) - 1);
            default: amt = AmtW'($urandom_range(0, 255));
         endcase
         send_beat(pick_op(), pick_operand(), pick_operand(), amt);
      end
      req_tvalid <= 1'b0;

      // drain, then hold on long enough to catch any stray result
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("wide_unsigned_alu_256_top_test passed");
      end else begin
         $display("wide_unsigned_alu_256_top_test failed");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #10_000_000;
      $display("wide_unsigned_alu_256_top_test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/wua_pkg.sv
design/wua_serial_adder.sv
design/wua_csa_mul.sv
design/wide_unsigned_alu_256_top.sv
design/wua_checker.sv
dv/wide_unsigned_alu_256_checker.sv
dv/wide_unsigned_alu_256_top_test.sv
